// ===== rtl/chte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

   localparam int DefBuckets = 509;
   localparam int DefNodes   = 256;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_OVERWRITE = 2'd1,
      OP_REMOVE    = 2'd2,
      OP_GET       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

endpackage

// ===== rtl/chte_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_front
// Accepts request items, computes the bucket (|key| mod BUCKETS) over a few
// registered steps, and pushes classified items into a two-deep queue.
// ----------------------------------------------------------------------------
module chte_front import chte_pkg::*; #(
   parameter int BUCKETS = DefBuckets,
   parameter int BW      = $clog2(BUCKETS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_opcode,
   input  logic [31:0]   req_key,
   input  logic [63:0]   req_entry_value,
   output logic          q_valid,
   input  logic          q_take,
   output logic [1:0]    q_op,
   output logic [31:0]   q_key,
   output logic [63:0]   q_val,
   output logic [BW-1:0] q_bucket
);
   localparam int QW = 2 + 32 + 64 + BW;

   // |key| is folded byte by byte with the residue of 2^(8i), then the small
   // sum is divided by reciprocal multiplication and the remainder taken
   localparam int SW = BW + 10;
   localparam int QB = SW - BW + 1;
   localparam int PW = 2 * SW + 2;
   localparam longint RECIP = ((longint'(1) << (SW + BW)) + longint'(BUCKETS) - 1) /
                              longint'(BUCKETS);
   localparam logic [BW-1:0] RES1 = BW'((longint'(1) << 8) % longint'(BUCKETS));
   localparam logic [BW-1:0] RES2 = BW'((longint'(1) << 16) % longint'(BUCKETS));
   localparam logic [BW-1:0] RES3 = BW'((longint'(1) << 24) % longint'(BUCKETS));

   logic          busy_ff, busy_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [31:0]   mag_ff, mag_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [QB-1:0] quo_ff, quo_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [PW-1:0] prod;
   logic [1:0]    op_ff;
   logic [31:0]   key_ff;
   logic [63:0]   val_ff;
   logic [1:0]    qn_ff, qn_in;
   logic [QW-1:0] qmem_ff [2];
   logic [QW-1:0] item;
   logic          push, done;

   assign req_stall = busy_ff;
   assign done  = busy_ff && (cnt_ff == 2'd3);
   assign push  = done && (qn_ff != 2'd2);
   assign prod  = PW'(sum_ff) * PW'(RECIP);
   assign item  = {op_ff, key_ff, val_ff, rem_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      sum_in  = sum_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (!busy_ff && req_valid) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mag_in  = req_key[31] ? (32'd0 - req_key) : req_key;
      end else if (busy_ff && !done) begin
         // three stages settle in turn while mag_ff holds
         cnt_in = cnt_ff + 2'd1;
         sum_in = SW'(mag_ff[7:0]) + SW'(mag_ff[15:8]) * SW'(RES1) +
                  SW'(mag_ff[23:16]) * SW'(RES2) + SW'(mag_ff[31:24]) * SW'(RES3);
         quo_in = prod[SW+BW +: QB];
         rem_in = BW'(sum_ff - SW'(SW'(quo_ff) * SW'(BUCKETS)));
      end else if (push) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      qn_in = qn_ff;
      if (push && !q_take)      qn_in = qn_ff + 2'd1;
      else if (!push && q_take) qn_in = qn_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         qn_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         qn_ff   <= qn_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (!busy_ff && req_valid) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_entry_value;
      end
      if (push && (qn_ff == (q_take ? 2'd1 : 2'd0))) qmem_ff[0] <= item;
      else if (q_take)                                qmem_ff[0] <= qmem_ff[1];
      if (push && !q_take && (qn_ff == 2'd1))        qmem_ff[1] <= item;
   end

   assign q_valid = (qn_ff != 2'd0);
   assign {q_op, q_key, q_val, q_bucket} = qmem_ff[0];

`ifndef SYNTHESIS
   a_qbound: assert property (@(posedge clock) disable iff (reset) qn_ff <= 2'd2)
      else $error("queue overflow");
   a_take: assert property (@(posedge clock) disable iff (reset) q_take |-> q_valid)
      else $error("take from empty queue");
   a_rem: assert property (@(posedge clock) disable iff (reset)
      done |-> (BW+1)'(rem_ff) < (BW+1)'(BUCKETS)) else $error("remainder out of range");
`endif
endmodule

// ===== rtl/chte_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_back
// Walks a bucket chain in the node memories and applies the operation.
// Bucket heads are cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module chte_back import chte_pkg::*; #(
   parameter int BUCKETS = DefBuckets,
   parameter int NODES   = DefNodes,
   parameter int BW      = $clog2(BUCKETS),
   parameter int NW      = $clog2(NODES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_take,
   input  logic [1:0]    q_op,
   input  logic [31:0]   q_key,
   input  logic [63:0]   q_val,
   input  logic [BW-1:0] q_bucket,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic          rsp_found,
   output logic [63:0]   rsp_value_out,
   output logic [8:0]    rsp_entry_count
);
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HEAD  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_CMP   = 7'b0010000,
      S_ACT   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type     state_ff;
   logic [NW:0]   heads   [BUCKETS];
   logic [31:0]   nkeys   [NODES];
   logic [63:0]   nvals   [NODES];
   logic [NW:0]   nlinks  [NODES];
   logic [NW-1:0] freemem [NODES];
   logic [BW-1:0] clr_ff;
   // free stack slots below fill_ff were never written and stand for their own index
   logic [NW:0]   ftop_ff, fill_ff, cnt_ff;
   logic [NW:0]   cur_ff, prev_ff, hd_ff, rlink_ff;
   logic [31:0]   rkey_ff;
   logic [63:0]   rval_ff;
   logic [NW-1:0] fpop_ff;
   logic [NW:0]   steps_ff;
   logic [1:0]    op_ff;
   logic [31:0]   key_ff;
   logic [63:0]   val_ff;
   logic [BW-1:0] bkt_ff;
   logic [NW:0]   none;
   logic [NW-1:0] cidx, fidx;

   assign none   = (NW+1)'(NODES);
   assign cidx   = cur_ff[NW-1:0];
   assign fidx   = NW'(ftop_ff - 1'b1);
   assign q_take = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      // registered memory reads
      hd_ff    <= heads[bkt_ff];
      rkey_ff  <= nkeys[cidx];
      rval_ff  <= nvals[cidx];
      rlink_ff <= nlinks[cidx];
      fpop_ff  <= freemem[fidx];
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         ftop_ff   <= none;
         fill_ff   <= none;
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               heads[clr_ff] <= none;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BW'(BUCKETS-1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (q_valid) begin
               op_ff    <= q_op;
               key_ff   <= q_key;
               val_ff   <= q_val;
               bkt_ff   <= q_bucket;
               prev_ff  <= none;
               steps_ff <= '0;
               state_ff <= S_HEAD;
            end
            S_HEAD: state_ff <= S_READ; // heads read lands in hd_ff
            S_READ: begin
               cur_ff   <= hd_ff;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // node read lands for S_ACT
               if (cur_ff == none || steps_ff == none) cur_ff <= none;
               state_ff <= S_ACT;
            end
            S_ACT: begin
               if (cur_ff != none && steps_ff != none && rkey_ff != key_ff) begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= rlink_ff;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_CMP;
               end else begin
                  logic hit;
                  hit = (cur_ff != none && steps_ff != none);
                  rsp_found       <= hit;
                  rsp_status      <= ST_OK;
                  rsp_value_out   <= '0;
                  rsp_entry_count <= 9'(cnt_ff);
                  case (opcode_type'(op_ff)) inside
                     OP_INSERT, OP_OVERWRITE: begin
                        if (hit) begin
                           if (op_ff == OP_OVERWRITE) begin
                              rsp_value_out <= rval_ff;
                              nvals[cidx]   <= val_ff;
                           end
                        end else if (ftop_ff == '0) begin
                           rsp_status <= ST_FULL;
                        end else begin
                           logic [NW-1:0] n;
                           n = (ftop_ff <= fill_ff) ? fidx : fpop_ff;
                           nkeys[n]  <= key_ff;
                           nvals[n]  <= val_ff;
                           nlinks[n] <= hd_ff;
                           heads[bkt_ff] <= {1'b0, n};
                           ftop_ff <= ftop_ff - 1'b1;
                           if (ftop_ff <= fill_ff) fill_ff <= ftop_ff - 1'b1;
                           cnt_ff <= cnt_ff + 1'b1;
                           rsp_entry_count <= 9'(cnt_ff + 1'b1);
                        end
                     end
                     OP_REMOVE: begin
                        if (!hit) rsp_status <= ST_NOTFOUND;
                        else begin
                           rsp_value_out <= rval_ff;
                           if (prev_ff == none) heads[bkt_ff] <= rlink_ff;
                           else nlinks[prev_ff[NW-1:0]] <= rlink_ff;
                           freemem[ftop_ff[NW-1:0]] <= cidx;
                           ftop_ff <= ftop_ff + 1'b1;
                           cnt_ff <= cnt_ff - 1'b1;
                           rsp_entry_count <= 9'(cnt_ff - 1'b1);
                        end
                     end
                     default: begin
                        if (!hit) rsp_status <= ST_NOTFOUND;
                        else rsp_value_out <= rval_ff;
                     end
                  endcase
                  rsp_valid <= 1'b1;
                  state_ff  <= S_OUT;
               end
            end
            S_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (cnt_ff + ftop_ff == none)) else $error("pool leak");
   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_OUT) else $error("response outside output state");
`endif
endmodule

// ===== rtl/chained_hash_table_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Keyed store with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries opcode, key and entry value; an item is taken when
//   req_valid is high and req_stall low. rsp_* returns one result item per
//   request (status, found, value_out, entry_count), taken when rsp_valid
//   is high and rsp_stall low.
//   The front folds |key| and reduces it mod BUCKETS in three registered
//   steps, then queues the item (two deep); it takes no new item until the
//   last one is queued. The back reads the bucket head, walks the chain one
//   node at a time, reading and comparing each, and presents the result.
//   Sustained rate is set by the back: it takes no new item until its result
//   is taken, and a longer chain walk lowers the rate.
//   After reset the back clears the bucket head memory, one entry a cycle;
//   queued items wait until it ends.
//   While rsp_stall is high the result holds and the back takes no item;
//   the front keeps filling the queue, then stalls the request side.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit import chte_pkg::*; #(
   parameter int BUCKETS = DefBuckets,
   parameter int NODES   = DefNodes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_key,
   input  logic [63:0] req_entry_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [63:0] rsp_value_out,
   output logic [8:0]  rsp_entry_count
);
   localparam int BW = $clog2(BUCKETS);

   logic          q_valid, q_take;
   logic [1:0]    q_op;
   logic [31:0]   q_key;
   logic [63:0]   q_val;
   logic [BW-1:0] q_bucket;

   chte_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_key,
      .req_entry_value, .q_valid, .q_take, .q_op, .q_key, .q_val, .q_bucket);

   chte_back #(.BUCKETS(BUCKETS), .NODES(NODES), .BW(BW)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_op, .q_key, .q_val, .q_bucket,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_found, .rsp_value_out,
      .rsp_entry_count);
endmodule
